// ===== sv/qcot_pkg.sv =====
// Package with the constants and word types of the quadrilateral corner overlap test.
package qcot_pkg;

  localparam int unsigned COORD_BITS  = 32;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned NUM_REGS    = 2 * NUM_CORNERS;
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam int unsigned DIFF_BITS   = COORD_BITS + 1;
  localparam int unsigned PROD_BITS   = 2 * DIFF_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [ID_BITS-1:0]           id_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

  typedef struct packed {
    id_t    quad_id;
    coord_t cand_x0;
    coord_t cand_y0;
    coord_t cand_x1;
    coord_t cand_y1;
    coord_t cand_x2;
    coord_t cand_y2;
    coord_t cand_x3;
    coord_t cand_y3;
  } in_word_t;

  typedef struct packed {
    id_t  result_id;
    logic overlaps;
  } out_word_t;

endpackage

// ===== sv/quad_corner_overlap_test.sv =====
// Top level of the quadrilateral corner overlap test: a four-stage edge sign pipeline.
//
//   channel   direction  handshake                  word
//   in        input      in_valid_i / in_ready_o    in_word_t: quad_id, eight corner coordinates
//   out       output     out_valid_o / out_ready_i  out_word_t: result_id, overlaps
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i (reference corners)
//
// A word is accepted every cycle while the output is not stalled by out_ready_i.
// The stages in order are: input register, differences, products, compare.
// Each stage moves on when it is empty or the stage after it moves, so bubbles close up.
// Reset clears all valid bits and sets the reference corners to zero.
// Configuration is always accepted; writes to indexes past the last register are dropped.
module quad_corner_overlap_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  qcot_pkg::in_word_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output qcot_pkg::out_word_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  qcot_pkg::cfg_idx_t         cfg_index_i,
  input  qcot_pkg::coord_t           cfg_data_i
);
  import qcot_pkg::*;

  coord_t ref_x_q [NUM_CORNERS];
  coord_t ref_y_q [NUM_CORNERS];

  logic     s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic     s1_ready, s2_ready, s3_ready, s4_ready;
  in_word_t s1_word_q;
  id_t      s2_id_q, s3_id_q;
  out_word_t out_word_q;

  coord_t cand_x [NUM_CORNERS];
  coord_t cand_y [NUM_CORNERS];

  diff_t dx_d [NUM_CORNERS];
  diff_t dy_d [NUM_CORNERS];
  diff_t ex_d [NUM_CORNERS][NUM_CORNERS];
  diff_t ey_d [NUM_CORNERS][NUM_CORNERS];
  diff_t dx_q [NUM_CORNERS];
  diff_t dy_q [NUM_CORNERS];
  diff_t ex_q [NUM_CORNERS][NUM_CORNERS];
  diff_t ey_q [NUM_CORNERS][NUM_CORNERS];

  prod_t p_d [NUM_CORNERS][NUM_CORNERS];
  prod_t m_d [NUM_CORNERS][NUM_CORNERS];
  prod_t p_q [NUM_CORNERS][NUM_CORNERS];
  prod_t m_q [NUM_CORNERS][NUM_CORNERS];

  logic [NUM_CORNERS-1:0] corner_hit;
  logic                   overlaps_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        ref_x_q[i] <= '0;
        ref_y_q[i] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_BITS'(NUM_REGS))) begin
      if (cfg_index_i[0]) begin
        ref_y_q[cfg_index_i[2:1]] <= cfg_data_i;
      end else begin
        ref_x_q[cfg_index_i[2:1]] <= cfg_data_i;
      end
    end
  end

  assign s4_ready   = !out_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s4_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_comb begin
    cand_x[0] = s1_word_q.cand_x0;
    cand_y[0] = s1_word_q.cand_y0;
    cand_x[1] = s1_word_q.cand_x1;
    cand_y[1] = s1_word_q.cand_y1;
    cand_x[2] = s1_word_q.cand_x2;
    cand_y[2] = s1_word_q.cand_y2;
    cand_x[3] = s1_word_q.cand_x3;
    cand_y[3] = s1_word_q.cand_y3;
  end

  always_comb begin
    for (int j = 0; j < NUM_CORNERS; j++) begin
      dx_d[j] = diff_t'(cand_x[(j + 1) % NUM_CORNERS]) - diff_t'(cand_x[j]);
      dy_d[j] = diff_t'(cand_y[(j + 1) % NUM_CORNERS]) - diff_t'(cand_y[j]);
      for (int i = 0; i < NUM_CORNERS; i++) begin
        ex_d[i][j] = diff_t'(ref_x_q[i]) - diff_t'(cand_x[j]);
        ey_d[i][j] = diff_t'(ref_y_q[i]) - diff_t'(cand_y[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      for (int j = 0; j < NUM_CORNERS; j++) begin
        p_d[i][j] = prod_t'(dy_q[j]) * prod_t'(ex_q[i][j]);
        m_d[i][j] = prod_t'(dx_q[j]) * prod_t'(ey_q[i][j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      corner_hit[i] = 1'b1;
      for (int j = 0; j < NUM_CORNERS; j++) begin
        corner_hit[i] = corner_hit[i] && (p_q[i][j] > m_q[i][j]);
      end
    end
    overlaps_d = |corner_hit;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_word_q <= in_data_i;
    end
    if (s1_valid_q && s2_ready) begin
      s2_id_q <= s1_word_q.quad_id;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      ex_q    <= ex_d;
      ey_q    <= ey_d;
    end
    if (s2_valid_q && s3_ready) begin
      s3_id_q <= s2_id_q;
      p_q     <= p_d;
      m_q     <= m_d;
    end
    if (s3_valid_q && s4_ready) begin
      out_word_q.result_id <= s3_id_q;
      out_word_q.overlaps  <= overlaps_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("Accepted word did not reach the input stage.");

  a_stall_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q && !out_ready_i)
    else $error("Input stalled while the pipeline had room.");

  a_s1_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> s2_valid_q)
    else $error("Word was lost between the input and difference stages.");

  a_s3_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s4_ready |=> out_valid_q)
    else $error("Word was lost between the product stage and the output.");

  a_bad_index_ignored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i >= CFG_IDX_BITS'(NUM_REGS))
    |=> $stable(ref_x_q[0]) && $stable(ref_y_q[0]) && $stable(ref_x_q[3])
        && $stable(ref_y_q[3]))
    else $error("Write past the register list changed a reference corner.");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the quadrilateral corner overlap test: directed table, then random words.
module tb_top;
  import qcot_pkg::*;

  localparam int unsigned PIPE_LAT        = 4;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned WORDS_PER_PHASE = 240;
  localparam coord_t C_MAX = 32'h7FFF_FFFF;
  localparam coord_t C_MIN = 32'h8000_0000;
  localparam coord_t UNIT  = 256;

  typedef enum int unsigned {
    REG_REF_X0, REG_REF_Y0, REG_REF_X1, REG_REF_Y1,
    REG_REF_X2, REG_REF_Y2, REG_REF_X3, REG_REF_Y3
  } ref_reg_e;

  typedef struct {
    in_word_t word;
    bit       known;
    logic     overlaps;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      cfg_valid_i = 1'b0;
  cfg_idx_t  cfg_index_i = '0;
  coord_t    cfg_data_i  = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_data_o;
  logic      cfg_ready_o;

  coord_t      ref_cx [NUM_CORNERS] = '{default: '0};
  coord_t      ref_cy [NUM_CORNERS] = '{default: '0};
  out_word_t   pending_results [$];
  out_word_t   head;
  dir_row_t    dir_tab [$];
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 49;

  quad_corner_overlap_test u_top (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic corner_overlap(in_word_t w);
    coord_t qx [NUM_CORNERS];
    coord_t qy [NUM_CORNERS];
    logic signed [DIFF_BITS:0]     dy, dx, rx, ry;
    logic signed [2*DIFF_BITS+1:0] p, q;
    logic all_pos;
    int unsigned k, j, n;
    qx = '{w.cand_x0, w.cand_x1, w.cand_x2, w.cand_x3};
    qy = '{w.cand_y0, w.cand_y1, w.cand_y2, w.cand_y3};
    for (k = 0; k < NUM_CORNERS; k++) begin
      all_pos = 1'b1;
      for (j = 0; j < NUM_CORNERS; j++) begin
        n  = (j + 1) % NUM_CORNERS;
        dy = qy[n] - qy[j];
        dx = qx[n] - qx[j];
        rx = ref_cx[k] - qx[j];
        ry = ref_cy[k] - qy[j];
        p  = dy * rx;
        q  = dx * ry;
        if (p <= q) all_pos = 1'b0;
      end
      if (all_pos) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  // Most candidates put one corner in each quadrant around a reference corner,
  // so the strict inside test is reached; some are reversed, on an edge, or noise.
  function automatic in_word_t make_candidate();
    in_word_t    w;
    longint      cx, cy, span;
    longint      ox [NUM_CORNERS];
    longint      oy [NUM_CORNERS];
    coord_t      qx [NUM_CORNERS];
    coord_t      qy [NUM_CORNERS];
    coord_t      t;
    int unsigned pick, k, i;
    pick = $urandom_range(99);
    k    = $urandom_range(NUM_CORNERS - 1);
    case ($urandom_range(3))
      0:       span = 16;
      1:       span = 1 << 12;
      2:       span = 1 << 20;
      default: span = 1 << 30;
    endcase
    cx = ref_cx[k];
    cy = ref_cy[k];
    if (pick < 25) begin
      cx = cx + longint'($urandom_range(2 * span)) - span;
      cy = cy + longint'($urandom_range(2 * span)) - span;
    end
    if (pick < 8) cx = cx + 3 * span;
    ox[0] = cx - longint'($urandom_range(span));
    oy[0] = cy - longint'($urandom_range(span));
    ox[1] = cx - longint'($urandom_range(span));
    oy[1] = cy + longint'($urandom_range(span));
    ox[2] = cx + longint'($urandom_range(span));
    oy[2] = cy + longint'($urandom_range(span));
    ox[3] = cx + longint'($urandom_range(span));
    oy[3] = cy - longint'($urandom_range(span));
    if ($urandom_range(9) == 0) begin
      ox[0] = cx;
      ox[1] = cx;
    end
    for (i = 0; i < NUM_CORNERS; i++) begin
      qx[i] = clamp_coord(ox[i]);
      qy[i] = clamp_coord(oy[i]);
    end
    if ($urandom_range(4) == 0) begin
      t = qx[1]; qx[1] = qx[3]; qx[3] = t;
      t = qy[1]; qy[1] = qy[3]; qy[3] = t;
    end
    if (pick >= 85) begin
      for (i = 0; i < NUM_CORNERS; i++) begin
        qx[i] = rand_coord();
        qy[i] = rand_coord();
      end
    end
    w.quad_id = id_t'($urandom());
    w.cand_x0 = qx[0];
    w.cand_y0 = qy[0];
    w.cand_x1 = qx[1];
    w.cand_y1 = qy[1];
    w.cand_x2 = qx[2];
    w.cand_y2 = qy[2];
    w.cand_x3 = qx[3];
    w.cand_y3 = qy[3];
    return w;
  endfunction

  task automatic add_dir(input id_t id, input coord_t x0, input coord_t y0,
                         input coord_t x1, input coord_t y1, input coord_t x2,
                         input coord_t y2, input coord_t x3, input coord_t y3,
                         input bit known, input logic ovl);
    dir_row_t r;
    r.word     = '{id, x0, y0, x1, y1, x2, y2, x3, y3};
    r.known    = known;
    r.overlaps = ovl;
    dir_tab = {dir_tab, r};
  endtask

  task automatic send_word(input in_word_t w, input bit known, input logic ovl);
    out_word_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    e.result_id = w.quad_id;
    e.overlaps  = known ? ovl : corner_overlap(w);
    pending_results = {pending_results, e};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_REGS) begin
      if (idx[0]) ref_cy[idx >> 1] = val;
      else        ref_cx[idx >> 1] = val;
    end
  endtask

  task automatic set_reference(input int unsigned kind);
    coord_t      v;
    int unsigned i, c;
    for (i = 0; i < NUM_REGS; i++) begin
      c = i / 2;
      case (kind)
        0:       v = (i % 2 == 0) ? ((c < 2) ? C_MIN : C_MAX)
                                  : ((c == 1 || c == 2) ? C_MAX : C_MIN);
        1, 4:    v = coord_t'(int'($urandom_range(2 ** 17)) - 2 ** 16);
        3:       v = $urandom_range(1) ? C_MAX : C_MIN;
        default: v = rand_coord();
      endcase
      write_reg(cfg_idx_t'(REG_REF_X0 + i), v);
    end
    write_reg(cfg_idx_t'($urandom_range(255, NUM_REGS)), rand_coord());
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result_id: expected none, actual %h", out_data_o.result_id);
        fail_cnt++;
      end else begin
        head = pending_results.pop_front();
        if (out_data_o.result_id !== head.result_id) begin
          $error("result_id: expected %h, actual %h", head.result_id, out_data_o.result_id);
          fail_cnt++;
        end
        if (out_data_o.overlaps !== head.overlaps) begin
          $error("overlaps: expected %b, actual %b", head.overlaps, out_data_o.overlaps);
          fail_cnt++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned i, phase, n;
    // With the reference corners at reset all four sit at the origin.
    add_dir(16'h0000, -UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT, UNIT, -UNIT, 1'b1, 1'b1);
    add_dir(16'hFFFF, -UNIT, -UNIT, UNIT, -UNIT, UNIT, UNIT, -UNIT, UNIT, 1'b1, 1'b0);
    add_dir(16'h0001, 0, -UNIT, 0, UNIT, UNIT, UNIT, UNIT, -UNIT, 1'b1, 1'b0);
    add_dir(16'h0002, 0, 0, UNIT, 0, UNIT, UNIT, 0, UNIT, 1'b1, 1'b0);
    add_dir(16'h0003, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
    add_dir(16'h7FFF, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, 1'b1, 1'b1);
    add_dir(16'h8000, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 1'b1, 1'b0);
    add_dir(16'h0004, -UNIT, 0, 0, 0, UNIT, 0, 2 * UNIT, 0, 1'b1, 1'b0);
    add_dir(16'h0005, -UNIT, -UNIT, -UNIT, UNIT, UNIT, 0, UNIT, 0, 1'b1, 1'b0);
    add_dir(16'h0006, -1, -1, -1, 1, 1, 1, 1, -1, 1'b1, 1'b1);
    add_dir(16'h0007, UNIT, UNIT, UNIT, 2 * UNIT, 2 * UNIT, 2 * UNIT, 2 * UNIT, UNIT,
            1'b1, 1'b0);
    add_dir(16'h5A5A, C_MIN, 0, 0, C_MAX, C_MAX, 0, 0, C_MIN, 1'b0, 1'b0);
    add_dir(16'hA5A5, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
    add_dir(16'h1234, -3 * UNIT, -UNIT, -UNIT, 5 * UNIT, 4 * UNIT, 2 * UNIT, UNIT, -7,
            1'b0, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < dir_tab.size(); i++)
      send_word(dir_tab[i].word, dir_tab[i].known, dir_tab[i].overlaps);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase / 2)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_reference(phase);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == 3 && n == WORDS_PER_PHASE / 2) wait_drained();
        send_word(make_candidate(), 1'b0, 1'b0);
      end
    end

    wait_drained();
    repeat (2 * PIPE_LAT) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
